// File: hw/rtl/see_pkg.sv
// Shared types, constants and saturation helpers for the stereo envelope expander.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package see_pkg;

  localparam int SmpW     = 16;
  localparam int EnvW     = 24;
  localparam int GainW    = 22;
  localparam int CoefW    = 16;
  localparam int LvlW     = 15;
  localparam int AccW     = 52;
  localparam int McW      = 34;
  localparam int MpW      = 25;
  localparam int CntW     = 5;
  localparam int DvdW     = 40;
  localparam int DivCntW  = 6;
  localparam int RndW     = AccW - 15;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  localparam logic signed [GainW-1:0] GainUnity = 22'sd65536;
  localparam logic signed [GainW-1:0] GainMax   = 22'sd2097151;
  localparam logic signed [GainW-1:0] GainMin   = -22'sd2097152;
  localparam logic [MpW-1:0]          RatioCap  = 25'h1000000;
  localparam logic [MpW-1:0]          SmoothTake = 25'd682;
  localparam logic [CntW-1:0]         CoefBits  = 5'd16;
  localparam logic [CntW-1:0]         RatioBits = 5'd25;
  localparam logic [CntW-1:0]         TakeBits  = 5'd10;

  localparam logic [CoefW-1:0] AttackRst  = 16'd65262;
  localparam logic [CoefW-1:0] ReleaseRst = 16'd65519;
  localparam logic [LvlW-1:0]  GateRst    = 15'd328;
  localparam logic [LvlW-1:0]  EnvLvlRst  = 15'd3277;
  localparam logic [CoefW-1:0] BoostRst   = 16'd12386;

  typedef enum logic [2:0] {
    REG_ATTACK  = 3'd0,
    REG_RELEASE = 3'd1,
    REG_GATE    = 3'd2,
    REG_ENVLVL  = 3'd3,
    REG_BOOST   = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ENV, S_ENV_W, S_COND, S_DIV, S_SQR, S_SQR_W,
    S_TERM, S_TERM_W, S_SMOOTH, S_SMOOTH_W, S_OUT, S_OUT_W, S_HOLD
  } core_state_e;

  typedef struct packed {
    logic [CoefW-1:0] attack_coef;
    logic [CoefW-1:0] release_coef;
    logic [LvlW-1:0]  gate_level;
    logic [LvlW-1:0]  envelope_level;
    logic [CoefW-1:0] boost_depth;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [McW-1:0]        mcand;
    logic [MpW-1:0]        mplier;
    logic [CntW-1:0]       nbits;
    logic                  neg_msb;
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [EnvW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // round half up, then drop 16 fraction bits
  function automatic logic signed [RndW-1:0] rnd16(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] w;
    w = v + AccW'(32768);
    return {w[AccW-1], w[AccW-1:16]};
  endfunction

  function automatic logic signed [GainW-1:0] sat_gain(input logic signed [RndW-1:0] v);
    logic signed [GainW-1:0] r;
    if (v > RndW'(signed'(GainMax))) r = GainMax;
    else if (v < RndW'(signed'(GainMin))) r = GainMin;
    else r = v[GainW-1:0];
    return r;
  endfunction

  function automatic logic signed [SmpW-1:0] sat_smp(input logic signed [RndW-1:0] v);
    logic signed [SmpW-1:0] r;
    if (v > RndW'(32767)) r = 16'sh7FFF;
    else if (v < -RndW'(32768)) r = 16'sh8000;
    else r = v[SmpW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/see_in_if.sv
// Input channel of the stereo envelope expander: one sample pair per item.
// Depends on see_pkg for the sample width.
`default_nettype none

interface see_in_if;
  import see_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SmpW-1:0] left_sample;
  logic signed [SmpW-1:0] right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/see_out_if.sv
// Result channel of the stereo envelope expander: one output pair per item.
// Depends on see_pkg for the sample width.
`default_nettype none

interface see_out_if;
  import see_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SmpW-1:0] left_out;
  logic signed [SmpW-1:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/see_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, optional negative MSB weight.
// Depends on see_pkg for request and status types.
`default_nettype none

module see_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  see_pkg::mul_req_t                req_i,
  output see_pkg::unit_sts_t               sts_o,
  output logic signed [see_pkg::AccW-1:0]  prod_o
);
  import see_pkg::*;

  logic signed [AccW-1:0] mc_q, mc_d, acc_q, acc_d, addend;
  logic [MpW-1:0]         mp_q, mp_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   neg_q, neg_d, busy_q, busy_d, done_q, done_d;

  always_comb begin
    mc_d   = mc_q;
    mp_d   = mp_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    addend = mp_q[0] ? mc_q : '0;
    if (req_i.start) begin
      mc_d   = {{(AccW-McW){req_i.mcand[McW-1]}}, req_i.mcand};
      mp_d   = req_i.mplier;
      cnt_d  = req_i.nbits;
      neg_d  = req_i.neg_msb;
      acc_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // with neg_msb set the multiplier is two's complement: the top bit weighs negative
      if (cnt_q == CntW'(1) && neg_q) acc_d = acc_q - addend;
      else acc_d = acc_q + addend;
      mc_d  = mc_q <<< 1;
      mp_d  = mp_q >> 1;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    acc_q <= acc_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

`default_nettype wire

// File: hw/rtl/see_div.sv
// Restoring divider: one quotient bit per cycle over a 40-bit dividend.
// Depends on see_pkg for request and status types.
`default_nettype none

module see_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  see_pkg::div_req_t           req_i,
  output see_pkg::unit_sts_t          sts_o,
  output logic [see_pkg::DvdW-1:0]    quo_o
);
  import see_pkg::*;

  logic [DvdW-1:0]    dvd_q, dvd_d, quo_q, quo_d;
  logic [EnvW-1:0]    dvs_q, dvs_d, rem_q, rem_d;
  logic [EnvW:0]      trial, diff;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;

  always_comb begin
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[DvdW-1]};
    diff   = trial - {1'b0, dvs_q};
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = DivCntW'(DvdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[EnvW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = trial[EnvW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/see_core.sv
// Per-item sequencer: runs left then right channel through the serial multiplier
// and divider, keeps envelope and gain state. Depends on see_pkg, see_mul, see_div.
`default_nettype none

module see_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  see_pkg::cfg_t                    cfg_i,
  input  logic                             start_i,
  input  logic signed [see_pkg::SmpW-1:0]  xl_i,
  input  logic signed [see_pkg::SmpW-1:0]  xr_i,
  input  logic                             load_ok_i,
  output logic                             idle_o,
  output logic                             push_o,
  output logic signed [see_pkg::SmpW-1:0]  yl_o,
  output logic signed [see_pkg::SmpW-1:0]  yr_o
);
  import see_pkg::*;

  core_state_e state_q, state_d;
  logic        ch_q, ch_d;

  logic signed [SmpW-1:0]  x_q [2];
  logic signed [SmpW-1:0]  x_d [2];
  logic signed [SmpW-1:0]  y_q [2];
  logic signed [SmpW-1:0]  y_d [2];
  logic [EnvW-1:0]         env_q [2];
  logic [EnvW-1:0]         env_d [2];
  logic signed [GainW-1:0] gain_q [2];
  logic signed [GainW-1:0] gain_d [2];

  logic [SmpW-1:0]         mag_q, mag_d;
  logic [EnvW-1:0]         m_q, m_d;
  logic [MpW-1:0]          r_q, r_d;
  logic [McW-1:0]          dk_q, dk_d;
  logic signed [GainW-1:0] t_q, t_d;

  logic signed [SmpW-1:0]  x_cur;
  logic [EnvW-1:0]         env_cur;
  logic signed [GainW-1:0] gain_cur;
  logic [SmpW-1:0]         mag_c;
  logic [EnvW-1:0]         m_c;
  logic [CoefW-1:0]        coef;
  logic [EnvW:0]           ediff;
  logic [GainW:0]          gdiff;
  logic signed [RndW-1:0]  rnd;
  logic [DvdW-1:0]         quo;
  logic signed [AccW-1:0]  prod;

  mul_req_t  mul_req;
  div_req_t  div_req;
  unit_sts_t mul_sts, div_sts;

  see_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .sts_o  (mul_sts),
    .prod_o (prod)
  );

  see_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts),
    .quo_o  (quo)
  );

  assign x_cur    = x_q[ch_q];
  assign env_cur  = env_q[ch_q];
  assign gain_cur = gain_q[ch_q];
  assign mag_c    = x_cur[SmpW-1] ? (SmpW'(0) - x_cur) : x_cur;
  assign m_c      = {mag_c, 8'h00};
  assign rnd      = rnd16(prod);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    x_d     = x_q;
    y_d     = y_q;
    env_d   = env_q;
    gain_d  = gain_q;
    mag_d   = mag_q;
    m_d     = m_q;
    r_d     = r_q;
    dk_d    = dk_q;
    t_d     = t_q;
    idle_o  = 1'b0;
    push_o  = 1'b0;
    mul_req = '0;
    div_req = '0;
    coef    = (m_c > env_cur) ? cfg_i.attack_coef : cfg_i.release_coef;
    ediff   = {1'b0, env_cur} - {1'b0, m_c};
    gdiff   = {t_q[GainW-1], t_q} - {gain_cur[GainW-1], gain_cur};

    unique case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          x_d[0]  = xl_i;
          x_d[1]  = xr_i;
          ch_d    = 1'b0;
          state_d = S_ENV;
        end
      end
      S_ENV: begin
        // env' = m + round(c * (env - m) / 2^16)
        mag_d           = mag_c;
        m_d             = m_c;
        mul_req.start   = 1'b1;
        mul_req.mcand   = {{(McW-EnvW-1){ediff[EnvW]}}, ediff};
        mul_req.mplier  = MpW'(coef);
        mul_req.nbits   = CoefBits;
        state_d         = S_ENV_W;
      end
      S_ENV_W: begin
        if (mul_sts.done) begin
          env_d[ch_q] = m_q + rnd[EnvW-1:0];
          state_d     = S_COND;
        end
      end
      S_COND: begin
        if (mag_q > {1'b0, cfg_i.gate_level} &&
            env_cur > {1'b0, cfg_i.envelope_level, 8'h00}) begin
          div_req.start    = 1'b1;
          div_req.dividend = {m_q, 16'h0000};
          div_req.divisor  = env_cur;
          state_d          = S_DIV;
        end else begin
          t_d     = GainUnity;
          state_d = S_SMOOTH;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          if (|quo[DvdW-1:MpW] || (quo[MpW-1] && |quo[MpW-2:0])) r_d = RatioCap;
          else r_d = quo[MpW-1:0];
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = McW'(r_q);
        mul_req.mplier = r_q;
        mul_req.nbits  = RatioBits;
        state_d        = S_SQR_W;
      end
      S_SQR_W: begin
        if (mul_sts.done) begin
          dk_d    = McW'(65536) - prod[McW+15:16];
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = dk_q;
        mul_req.mplier = MpW'(cfg_i.boost_depth);
        mul_req.nbits  = CoefBits;
        state_d        = S_TERM_W;
      end
      S_TERM_W: begin
        if (mul_sts.done) begin
          t_d     = sat_gain(RndW'(65536) + rnd);
          state_d = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        // g' = g + round(take * (t - g) / 2^16)
        mul_req.start  = 1'b1;
        mul_req.mcand  = {{(McW-GainW-1){gdiff[GainW]}}, gdiff};
        mul_req.mplier = SmoothTake;
        mul_req.nbits  = TakeBits;
        state_d        = S_SMOOTH_W;
      end
      S_SMOOTH_W: begin
        if (mul_sts.done) begin
          gain_d[ch_q] = sat_gain({{(RndW-GainW){gain_cur[GainW-1]}}, gain_cur} + rnd);
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        mul_req.start   = 1'b1;
        mul_req.mcand   = {{(McW-GainW){gain_cur[GainW-1]}}, gain_cur};
        mul_req.mplier  = MpW'(x_cur[SmpW-1:0]);
        mul_req.nbits   = CoefBits;
        mul_req.neg_msb = 1'b1;
        state_d         = S_OUT_W;
      end
      S_OUT_W: begin
        if (mul_sts.done) begin
          y_d[ch_q] = sat_smp(rnd);
          if (!ch_q) begin
            ch_d    = 1'b1;
            state_d = S_ENV;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        // hold both results until the output register frees up
        push_o = 1'b1;
        if (load_ok_i) begin
          ch_d    = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ch_q      <= 1'b0;
      env_q[0]  <= '0;
      env_q[1]  <= '0;
      gain_q[0] <= GainUnity;
      gain_q[1] <= GainUnity;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      env_q   <= env_d;
      gain_q  <= gain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    mag_q <= mag_d;
    m_q   <= m_d;
    r_q   <= r_d;
    dk_q  <= dk_d;
    t_q   <= t_d;
  end

  assign yl_o = y_q[0];
  assign yr_o = y_q[1];

`ifndef SYNTHESIS
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_sts.busy)
    else $error("multiplier started while busy");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_sts.busy)
    else $error("divider started while busy");
  a_start_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && idle_o |=> state_q == S_ENV && !ch_q)
    else $error("item did not start on the left channel");
  a_push_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> ch_q && !mul_sts.busy && !div_sts.busy)
    else $error("result pushed before both channels finished");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/stereo_envelope_expander.sv
// Stereo envelope-following upward expander.
// Input smp_i carries one stereo sample pair per item; res_o returns one
// gain-adjusted pair per item, in order. Items use valid/ready handshakes.
// The APB port holds five registers (attack, release, gate level, envelope
// level, boost depth) at byte addresses 0, 4, 8, 12, 16; pready is always high.
// Each item runs the left and then the right channel through one shift-add
// multiplier (one multiplier bit per cycle) and one restoring divider (one
// quotient bit per cycle). A channel below the gate skips the division, the
// ratio square and the boost term; for an expanding channel the division and
// the ratio square dominate. The next item is accepted once the previous one
// has moved to the output register.
// A registered output stage holds the result while res_o is stalled; a new
// item is still accepted then, and its result waits until the register frees.
// Reset clears both envelopes to zero, sets both gains to unity and loads the
// register defaults. Depends on see_pkg, see_in_if, see_out_if, see_core.
`default_nettype none

module stereo_envelope_expander (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  see_in_if.sink                       smp_i,
  see_out_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [see_pkg::AddrW-1:0]    paddr,
  input  logic [see_pkg::DataW-1:0]    pwdata,
  output logic [see_pkg::DataW-1:0]    prdata,
  output logic                         pready
);
  import see_pkg::*;

  cfg_t                   cfg_q, cfg_d;
  reg_idx_e               reg_idx;
  logic                   wr_en;
  logic                   idle, push, load_ok;
  logic signed [SmpW-1:0] yl, yr;
  logic                   out_valid_q, out_valid_d;
  logic signed [SmpW-1:0] out_l_q, out_l_d, out_r_q, out_r_d;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (reg_idx)
      REG_ATTACK: begin
        prdata = DataW'(cfg_q.attack_coef);
        if (wr_en) cfg_d.attack_coef = pwdata[CoefW-1:0];
      end
      REG_RELEASE: begin
        prdata = DataW'(cfg_q.release_coef);
        if (wr_en) cfg_d.release_coef = pwdata[CoefW-1:0];
      end
      REG_GATE: begin
        prdata = DataW'(cfg_q.gate_level);
        if (wr_en) cfg_d.gate_level = pwdata[LvlW-1:0];
      end
      REG_ENVLVL: begin
        prdata = DataW'(cfg_q.envelope_level);
        if (wr_en) cfg_d.envelope_level = pwdata[LvlW-1:0];
      end
      REG_BOOST: begin
        prdata = DataW'(cfg_q.boost_depth);
        if (wr_en) cfg_d.boost_depth = pwdata[CoefW-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coef    <= AttackRst;
      cfg_q.release_coef   <= ReleaseRst;
      cfg_q.gate_level     <= GateRst;
      cfg_q.envelope_level <= EnvLvlRst;
      cfg_q.boost_depth    <= BoostRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  see_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .start_i   (smp_i.valid && idle),
    .xl_i      (smp_i.left_sample),
    .xr_i      (smp_i.right_sample),
    .load_ok_i (load_ok),
    .idle_o    (idle),
    .push_o    (push),
    .yl_o      (yl),
    .yr_o      (yr)
  );

  assign smp_i.ready = idle;
  assign load_ok     = !out_valid_q || res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    if (push && load_ok) begin
      out_valid_d = 1'b1;
      out_l_d     = yl;
      out_r_d     = yr;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    out_l_q <= out_l_d;
    out_r_q <= out_r_d;
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.left_out  = out_l_q;
  assign res_o.right_out = out_r_q;

endmodule

`default_nettype wire

// File: tb/tb_stereo_envelope_expander.sv
// Self-checking testbench for the stereo envelope expander: drives sample pairs,
// writes the APB registers between phases and checks every output pair.
// Depends on see_pkg, see_in_if, see_out_if and the stereo_envelope_expander RTL.
`timescale 1ns / 1ps

module tb_stereo_envelope_expander;
  import see_pkg::*;

  typedef struct packed {
    logic signed [SmpW-1:0] left_out;
    logic signed [SmpW-1:0] right_out;
  } pair_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  see_in_if  smp_if ();
  see_out_if res_if ();

  stereo_envelope_expander u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .smp_i(smp_if.sink), .res_o(res_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the registers and channel state
  cfg_t        cfg_q;
  logic [23:0] env_l, env_r;
  longint      gain_l, gain_r;

  pair_t expected_q[$];
  int    err_cnt;
  bit    hold_off;
  bit    stall_en;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb_stereo_envelope_expander: errors");
    $finish;
  end

  function automatic longint rnd_half_up(longint v, int s);
    longint w;
    w = v + (longint'(1) << (s - 1));
    return w >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SmpW-1:0] expand_channel(
      input logic signed [SmpW-1:0] x, inout logic [23:0] env, inout longint gain);
    longint xs, mag, m, c, e, r, k, tgt, g;
    xs  = longint'(x);
    mag = (xs < 0) ? -xs : xs;
    m   = mag << 8;
    c   = (m > longint'(env)) ? longint'(cfg_q.attack_coef) : longint'(cfg_q.release_coef);
    e   = (((65536 - c) * m + c * longint'(env) + 32768) >> 16) & 64'hFFFFFF;
    env = e[23:0];
    tgt = 65536;
    if (mag > longint'(cfg_q.gate_level) && e > (longint'(cfg_q.envelope_level) << 8)) begin
      r = (m << 16) / e;
      if (r > 64'd16777216) r = 16777216;
      k = (r * r) >> 16;
      tgt = clamp(65536 + rnd_half_up(longint'(cfg_q.boost_depth) * (65536 - k), 16),
                  -2097152, 2097151);
    end
    g = clamp(rnd_half_up(64854 * gain + 682 * tgt, 16), -2097152, 2097151);
    gain = g;
    return 16'(clamp(rnd_half_up(xs * g, 16), -32768, 32767));
  endfunction

  task automatic reg_write(reg_idx_e idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = AddrW'(idx) << 2; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_ATTACK:  cfg_q.attack_coef    = val[15:0];
      REG_RELEASE: cfg_q.release_coef   = val[15:0];
      REG_GATE:    cfg_q.gate_level     = val[14:0];
      REG_ENVLVL:  cfg_q.envelope_level = val[14:0];
      REG_BOOST:   cfg_q.boost_depth    = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] atk, logic [15:0] rel, logic [14:0] gate,
                         logic [14:0] elvl, logic [15:0] boost);
    reg_write(REG_ATTACK, atk);
    reg_write(REG_RELEASE, rel);
    reg_write(REG_GATE, gate);
    reg_write(REG_ENVLVL, elvl);
    reg_write(REG_BOOST, boost);
  endtask

  // hand one pair to the block and queue its predicted output
  task automatic send_pair(logic signed [SmpW-1:0] l, logic signed [SmpW-1:0] r);
    pair_t p;
    @(negedge clk_i);
    smp_if.valid        <= 1'b1;
    smp_if.left_sample  <= l;
    smp_if.right_sample <= r;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    p.left_out  = expand_channel(l, env_l, gain_l);
    p.right_out = expand_channel(r, env_r, gain_r);
    expected_q.push_back(p);
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
  endtask

  // bursts of back-to-back items separated by random gaps
  task automatic send_burst_pair(logic signed [SmpW-1:0] l, logic signed [SmpW-1:0] r);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 40)) @(negedge clk_i);
    send_pair(l, r);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic signed [SmpW-1:0] rand_smp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return SmpW'($urandom_range(0, 600)) - 16'sd300;
      default: return SmpW'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [SmpW-1:0] vals[8];
    vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1, 16'sd329, -16'sd328, 16'sh5555};
    foreach (vals[i]) send_pair(vals[i], vals[7 - i]);
    // loud pulse after quiet envelope drives the ratio far above one
    repeat (3) send_pair(16'sd4000, -16'sd4000);
    send_pair(16'sh7FFF, 16'sh8000);
    drain();
  endtask

  task automatic test_zero_coef();
    set_all(16'd0, 16'd0, 15'd0, 15'd0, 16'hFFFF);
    send_pair(16'sd20000, -16'sd20000);
    send_pair(16'sd100, -16'sd50);
    send_pair(16'sh8000, 16'sh7FFF);
    drain();
    // slow envelope, tiny levels: huge ratio saturates
    set_all(16'hFFFF, 16'hFFFF, 15'd0, 15'd0, 16'hFFFF);
    send_pair(16'sd1, 16'sd1);
    repeat (4) send_pair(16'sh7FFF, 16'sh8000);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_burst_pair(rand_smp(), rand_smp());
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (12) send_burst_pair(rand_smp(), rand_smp());
    drain();
  endtask

  // receiver: stall pattern, plus one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        res_if.ready <= 1'b0;
        repeat (1500) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (stall_en) begin
        res_if.ready <= ($urandom_range(0, 3) != 0);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // compare every accepted output pair with the oldest prediction
  always @(posedge clk_i) begin
    pair_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected pair %0d %0d", $time, res_if.left_out, res_if.right_out);
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (want.left_out !== res_if.left_out) begin
          $display("%0t: left_out expected %0d actual %0d", $time, want.left_out,
                   res_if.left_out);
          err_cnt++;
        end
        if (want.right_out !== res_if.right_out) begin
          $display("%0t: right_out expected %0d actual %0d", $time, want.right_out,
                   res_if.right_out);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    err_cnt = 0; hold_off = 1'b0; stall_en = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    smp_if.valid = 1'b0; smp_if.left_sample = '0; smp_if.right_sample = '0;
    cfg_q = '{AttackRst, ReleaseRst, GateRst, EnvLvlRst, BoostRst};
    env_l = '0; env_r = '0; gain_l = 65536; gain_r = 65536;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_zero_coef();
    stall_en = 1'b1;
    set_all(AttackRst, ReleaseRst, GateRst, EnvLvlRst, BoostRst);
    test_random(200);
    set_all(16'd30000, 16'd60000, 15'h7FFF, 15'h7FFF, 16'd40000);
    test_random(100);
    set_all(16'd1000, 16'd2000, 15'd50, 15'd100, 16'd0);
    test_random(100);
    set_all(16'($urandom), 16'($urandom), 15'($urandom_range(0, 2000)),
            15'($urandom_range(0, 6000)), 16'($urandom));
    test_backpressure();
    test_random(200);

    if (err_cnt == 0) $display("tb_stereo_envelope_expander: clean");
    else $display("tb_stereo_envelope_expander: errors");
    $finish;
  end

endmodule
